FILE: src/ccm_cbc_mac_frame_authenticator_top_assert.svh
// ----------------------------------------------------------------------------
// CCM authenticator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CCM_CBC_MAC_FRAME_AUTHENTICATOR_TOP_ASSERT_SVH
`define CCM_CBC_MAC_FRAME_AUTHENTICATOR_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define CCM_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ccm assertion failed");

// next-cycle implication, off during reset
`define CCM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ccm assertion failed");

// next-cycle implication, also checked through reset
`define CCM_ASSERT_ALWAYS(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("ccm assertion failed");

`endif

FILE: src/ccm_pkg.sv
// ----------------------------------------------------------------------------
// CCM package
// Types, constants and AES round functions for the CBC-MAC authenticator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ccm_pkg;

    localparam int MAX_FRAME_BYTES = 127;
    localparam logic [7:0] B0_FLAGS = 8'h49;

    typedef enum logic [1:0] {
        MODE_HDR   = 2'd0,
        MODE_ASSOC = 2'd1,
        MODE_MSG   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_KEY_UPPER = 2'd0,
        REG_KEY_LOWER = 2'd1,
        REG_TAG_LEN   = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        TAGLEN_4  = 2'd0,
        TAGLEN_8  = 2'd1
    } t_taglen;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ASSOC = 2'd1,
        PH_MSG   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ABSORB = 2'd0,
        CMD_TAG    = 2'd1,
        CMD_ERR    = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_AES  = 2'd1,
        B_TAG  = 2'd2
    } t_back_state;

    typedef struct packed {
        t_cmd_kind    kind;
        logic         restart;
        logic [3:0]   tag_last;
        logic [127:0] data;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic not_empty;
        t_cmd cmd;
    } t_head;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction

    // SubBytes, ShiftRows and, unless final, MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
        logic [7:0]   t [16];
        logic [7:0]   u [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[get_byte(s, i)];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                u[i + 4 * c] = t[i + 4 * ((c + i) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = u[4 * c];
            a1 = u[4 * c + 1];
            a2 = u[4 * c + 2];
            a3 = u[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!fin) begin
                u[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
                u[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                u[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                u[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = u[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
        logic [7:0]   b [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            b[i] = get_byte(k, i);
        end
        b[0] = b[0] ^ SBOX[b[13]] ^ rcon;
        b[1] = b[1] ^ SBOX[b[14]];
        b[2] = b[2] ^ SBOX[b[15]];
        b[3] = b[3] ^ SBOX[b[12]];
        for (int i = 4; i < 16; i++) begin
            b[i] = b[i] ^ b[i - 4];
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = b[i];
        end
        return r;
    endfunction

endpackage

FILE: src/ccm_front.sv
// ----------------------------------------------------------------------------
// CCM front end
// Accepts header and data items, assembles blocks and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [63:0]       i_source_address,
    input  logic [39:0]       i_slot_number,
    input  logic [6:0]        i_assoc_length,
    input  logic [6:0]        i_message_length,
    input  logic [7:0]        i_data_byte,
    input  logic [1:0]        i_tag_length_code,
    input  logic              i_q_ready,
    output ccm_pkg::t_push    o_push
);
    import ccm_pkg::*;

    t_phase       r_phase, n_phase;
    logic [3:0]   r_pos, n_pos;
    logic [6:0]   r_arem, n_arem;
    logic [6:0]   r_mrem, n_mrem;
    logic [127:0] r_asm, n_asm;
    logic         r_pend_pad, n_pend_pad;
    logic         r_pend_tag, n_pend_tag;

    logic         acc;
    logic [7:0]   len_sum;
    logic [127:0] with_byte;
    logic [127:0] padded;
    logic [3:0]   tag_last;
    logic         take_byte;
    logic         part_end;

    assign o_in_ready = !r_pend_pad && !r_pend_tag && i_q_ready;
    assign acc        = i_in_valid && o_in_ready;
    assign len_sum    = {1'b0, i_assoc_length} + {1'b0, i_message_length};

    always_comb begin
        case (i_tag_length_code)
            TAGLEN_4: tag_last = 4'd3;
            TAGLEN_8: tag_last = 4'd7;
            default:  tag_last = 4'd15;
        endcase
    end

    always_comb begin
        with_byte = r_asm;
        with_byte[127 - 8 * r_pos -: 8] = i_data_byte;
        for (int i = 0; i < 16; i++) begin
            padded[127 - 8 * i -: 8] = (4'(i) <= r_pos) ? with_byte[127 - 8 * i -: 8] : 8'h00;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_arem     = r_arem;
        n_mrem     = r_mrem;
        n_asm      = r_asm;
        n_pend_pad = r_pend_pad;
        n_pend_tag = r_pend_tag;
        o_push     = '0;
        o_push.cmd.tag_last = tag_last;
        take_byte  = 1'b0;
        part_end   = 1'b0;

        if (r_pend_pad && i_q_ready) begin
            o_push.push     = 1'b1;
            o_push.cmd.kind = CMD_ABSORB;
            n_pend_pad      = 1'b0;
        end else if (r_pend_tag && i_q_ready) begin
            o_push.push     = 1'b1;
            o_push.cmd.kind = CMD_TAG;
            n_pend_tag      = 1'b0;
        end else if (acc) begin
            case (i_mode)
                MODE_HDR: begin
                    if (len_sum > 8'(MAX_FRAME_BYTES)) begin
                        o_push.push     = 1'b1;
                        o_push.cmd.kind = CMD_ERR;
                        n_phase         = PH_IDLE;
                    end else begin
                        o_push.push        = 1'b1;
                        o_push.cmd.kind    = CMD_ABSORB;
                        o_push.cmd.restart = 1'b1;
                        o_push.cmd.data    = {8'h00, 1'b0, i_message_length, i_slot_number,
                                              i_source_address, B0_FLAGS};
                        n_asm[127:112]     = {8'h00, 1'b0, i_assoc_length};
                        n_pos              = 4'd2;
                        n_arem             = i_assoc_length;
                        n_mrem             = i_message_length;
                        n_phase            = PH_ASSOC;
                        if (i_assoc_length == 7'd0) begin
                            n_pend_pad = 1'b1;
                            n_pos      = 4'd0;
                            n_phase    = PH_MSG;
                            if (i_message_length == 7'd0) begin
                                n_pend_tag = 1'b1;
                                n_phase    = PH_IDLE;
                            end
                        end
                    end
                end
                MODE_ASSOC: begin
                    if (r_phase == PH_ASSOC && r_arem != 7'd0) begin
                        take_byte = 1'b1;
                        part_end  = (r_arem == 7'd1);
                        n_arem    = r_arem - 7'd1;
                        if (part_end) begin
                            n_phase = PH_MSG;
                            if (r_mrem == 7'd0) begin
                                n_pend_tag = 1'b1;
                                n_phase    = PH_IDLE;
                            end
                        end
                    end
                end
                MODE_MSG: begin
                    if (r_phase == PH_MSG && r_mrem != 7'd0) begin
                        take_byte = 1'b1;
                        part_end  = (r_mrem == 7'd1);
                        n_mrem    = r_mrem - 7'd1;
                        if (part_end) begin
                            n_pend_tag = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (take_byte) begin
                n_asm = with_byte;
                n_pos = part_end ? 4'd0 : r_pos + 4'd1;
                if (part_end || r_pos == 4'd15) begin
                    o_push.push     = 1'b1;
                    o_push.cmd.kind = CMD_ABSORB;
                    o_push.cmd.data = padded;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_arem     <= '0;
            r_mrem     <= '0;
            r_pend_pad <= 1'b0;
            r_pend_tag <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_arem     <= n_arem;
            r_mrem     <= n_mrem;
            r_pend_pad <= n_pend_pad;
            r_pend_tag <= n_pend_tag;
        end
        r_asm <= n_asm;
    end

endmodule

FILE: src/ccm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// CCM command queue
// Two-entry queue between the front end and the cipher back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccm_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ccm_pkg::t_push i_push,
    output logic           o_ready,
    input  logic           i_pop,
    output ccm_pkg::t_head o_head
);
    import ccm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_ready          = (r_cnt != 2'd2);
    assign do_push          = i_push.push && o_ready;
    assign do_pop           = i_pop && (r_cnt != 2'd0);
    assign o_head.not_empty = (r_cnt != 2'd0);
    assign o_head.cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

endmodule

FILE: src/ccm_back.sv
// ----------------------------------------------------------------------------
// CCM back end
// Iterative AES-128 chaining unit and tag byte output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [127:0]   i_key,
    input  ccm_pkg::t_head i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_tag_byte,
    output logic           o_status,
    output logic           o_last
);
    import ccm_pkg::*;

    t_back_state  r_state, n_state;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_st, n_st;
    logic [127:0] r_rk, n_rk;
    logic [7:0]   r_rcon, n_rcon;
    logic [3:0]   r_rnd, n_rnd;
    logic [3:0]   r_tidx, n_tidx;
    logic [3:0]   r_tlast, n_tlast;
    logic         r_ovalid, n_ovalid;
    logic [7:0]   r_otag, n_otag;
    logic         r_ostat, n_ostat;
    logic         r_olast, n_olast;

    logic         slot_free;
    logic [127:0] rk_nx;
    logic [127:0] st_nx;

    assign slot_free   = !r_ovalid || i_out_ready;
    assign rk_nx       = key_next(r_rk, r_rcon);
    assign st_nx       = aes_round(r_st, r_rnd == 4'd10) ^ rk_nx;
    assign o_out_valid = r_ovalid;
    assign o_tag_byte  = r_otag;
    assign o_status    = r_ostat;
    assign o_last      = r_olast;

    always_comb begin
        n_state  = r_state;
        n_chain  = r_chain;
        n_st     = r_st;
        n_rk     = r_rk;
        n_rcon   = r_rcon;
        n_rnd    = r_rnd;
        n_tidx   = r_tidx;
        n_tlast  = r_tlast;
        n_ovalid = r_ovalid && !i_out_ready;
        n_otag   = r_otag;
        n_ostat  = r_ostat;
        n_olast  = r_olast;
        o_pop    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_head.not_empty) begin
                    case (i_head.cmd.kind)
                        CMD_ABSORB: begin
                            o_pop   = 1'b1;
                            n_st    = i_head.cmd.data ^ i_key
                                      ^ (i_head.cmd.restart ? 128'd0 : r_chain);
                            n_rk    = i_key;
                            n_rcon  = 8'h01;
                            n_rnd   = 4'd1;
                            n_state = B_AES;
                        end
                        CMD_TAG: begin
                            o_pop   = 1'b1;
                            n_tidx  = 4'd0;
                            n_tlast = i_head.cmd.tag_last;
                            n_state = B_TAG;
                        end
                        default: begin
                            if (slot_free) begin
                                o_pop    = 1'b1;
                                n_ovalid = 1'b1;
                                n_otag   = 8'h00;
                                n_ostat  = 1'b1;
                                n_olast  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            B_AES: begin
                n_st   = st_nx;
                n_rk   = rk_nx;
                n_rcon = xtime(r_rcon);
                n_rnd  = r_rnd + 4'd1;
                if (r_rnd == 4'd10) begin
                    n_chain = st_nx;
                    n_state = B_IDLE;
                end
            end
            B_TAG: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_otag   = r_chain[127 - 8 * r_tidx -: 8];
                    n_ostat  = 1'b0;
                    n_olast  = (r_tidx == r_tlast);
                    n_tidx   = r_tidx + 4'd1;
                    if (r_tidx == r_tlast) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_chain  <= '0;
            r_rnd    <= '0;
            r_tidx   <= '0;
            r_tlast  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_rnd    <= n_rnd;
            r_tidx   <= n_tidx;
            r_tlast  <= n_tlast;
            r_ovalid <= n_ovalid;
        end
        r_st    <= n_st;
        r_rk    <= n_rk;
        r_rcon  <= n_rcon;
        r_otag  <= n_otag;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

endmodule

FILE: src/ccm_cbc_mac_frame_authenticator_top.sv
// ----------------------------------------------------------------------------
// CCM CBC-MAC frame authenticator
// AES-128 CBC-MAC over header, associated data and message of one frame.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): a header item starts a frame, then
// associated-data bytes and message bytes follow one per transfer. Data bytes
// are taken one per cycle while the command queue has room; a header or the
// last byte of a frame also holds the input until each extra command it adds
// (padding block, tag request) is queued. Output channel (o_out_valid /
// i_out_ready): 4, 8 or 16 tag bytes, or one error result when the two
// lengths add up to over 127, last set on the final. Each 16-byte block runs
// through the iterative AES unit (load plus ten rounds); a two-entry command
// queue sits between the byte front end and the cipher, so bytes keep
// streaming while a block is enciphered. Tag bytes leave one per cycle while
// the receiver is ready; a stalled receiver holds the output register, and
// the front end takes bytes until the queue fills. Reset clears all control
// state; a write port loads key and tag length, only while idle (unenforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccm_cbc_mac_frame_authenticator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_source_address,
    input  logic [39:0] i_slot_number,
    input  logic [6:0]  i_assoc_length,
    input  logic [6:0]  i_message_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tag_byte,
    output logic        o_status,
    output logic        o_last
);
    import ccm_pkg::*;

    logic [63:0] r_key_upper;
    logic [63:0] r_key_lower;
    logic [1:0]  r_tag_len;
    t_push       push;
    t_head       head;
    logic        q_ready;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
            r_tag_len   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_UPPER: r_key_upper <= i_cfg_wdata;
                REG_KEY_LOWER: r_key_lower <= i_cfg_wdata;
                REG_TAG_LEN:   r_tag_len   <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    ccm_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_source_address  (i_source_address),
        .i_slot_number     (i_slot_number),
        .i_assoc_length    (i_assoc_length),
        .i_message_length  (i_message_length),
        .i_data_byte       (i_data_byte),
        .i_tag_length_code (r_tag_len),
        .i_q_ready         (q_ready),
        .o_push            (push)
    );

    ccm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_head  (head)
    );

    ccm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       ({r_key_upper, r_key_lower}),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tag_byte  (o_tag_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

FILE: src/ccm_checker.sv
// ----------------------------------------------------------------------------
// CCM port checker
// Port-level properties of the authenticator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ccm_cbc_mac_frame_authenticator_top_assert.svh"
module ccm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_tag_byte,
    input logic       o_status,
    input logic       o_last
);
    `CCM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `CCM_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_tag_byte))
    `CCM_ASSERT_NOW(a_err_form, o_out_valid && o_status, o_last && o_tag_byte == 8'h00)
    `CCM_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n, !o_out_valid)
endmodule

bind ccm_cbc_mac_frame_authenticator_top ccm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_tag_byte  (o_tag_byte),
    .o_status    (o_status),
    .o_last      (o_last)
);
